### sv/dual_radio_relay_state_control_assert.svh
// Assertion macros for the dual-radio relay control checker.
// Expects clk and rst in scope at the point of use.
`ifndef DUAL_RADIO_RELAY_STATE_CONTROL_ASSERT_SVH
`define DUAL_RADIO_RELAY_STATE_CONTROL_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define DRRSC_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// Next-cycle implication, disabled in reset.
`define DRRSC_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

### sv/drrsc_pkg.sv
// Shared types and constants for the dual-radio relay control block.
// No dependencies.
package drrsc_pkg;

  localparam int RELAY_W = 11;

  localparam logic [2:0] MODE_FSW_ONE = 3'd0;
  localparam logic [2:0] MODE_FSW_TWO = 3'd1;
  localparam logic [2:0] MODE_SUPPORT = 3'd2;
  localparam logic [2:0] MODE_PRIO    = 3'd3;
  localparam logic [2:0] MODE_ANT_ONE = 3'd4;
  localparam logic [2:0] MODE_ANT_TWO = 3'd5;
  localparam logic [2:0] MODE_MUTE    = 3'd6;

  localparam logic [1:0] SET_OFF = 2'd0;
  localparam logic [1:0] SET_ON  = 2'd1;

  localparam logic [1:0] PRIO_FIRST = 2'd0;
  localparam logic [1:0] PRIO_ONE   = 2'd1;
  localparam logic [1:0] PRIO_TWO   = 2'd2;

  localparam logic [RELAY_W-1:0] K4    = 11'h001;
  localparam logic [RELAY_W-1:0] K5K6  = 11'h002;
  localparam logic [RELAY_W-1:0] K8    = 11'h004;
  localparam logic [RELAY_W-1:0] K9    = 11'h008;
  localparam logic [RELAY_W-1:0] K10   = 11'h010;
  localparam logic [RELAY_W-1:0] K11   = 11'h020;
  localparam logic [RELAY_W-1:0] K12   = 11'h040;
  localparam logic [RELAY_W-1:0] K13   = 11'h080;
  localparam logic [RELAY_W-1:0] K14   = 11'h100;
  localparam logic [RELAY_W-1:0] TRANS = 11'h200;
  localparam logic [RELAY_W-1:0] RELAY_MASK = 11'h3FF;

  typedef enum logic [1:0] {
    CMD_NONE  = 2'd0,
    CMD_ENTER = 2'd1,
    CMD_EXIT  = 2'd2
  } seq_cmd_t;

  localparam logic [1:0] CMD_INVALID = 2'd3;

  typedef struct packed {
    logic [1:0] fsw_one;
    logic [1:0] fsw_two;
    logic [1:0] support_op;
    logic [1:0] prio_sel;
    logic [1:0] ant_one;
    logic [1:0] ant_two;
    logic [1:0] mute;
  } settings_t;

  typedef struct packed {
    logic [RELAY_W-1:0] relay;
    seq_cmd_t           cmd_one;
    seq_cmd_t           cmd_two;
  } decision_t;

endpackage

### sv/drrsc_decide.sv
// Relay and sequencer decision table, evaluated on the updated settings.
// Depends on drrsc_pkg.
module drrsc_decide import drrsc_pkg::*; (
  input  settings_t          settings,
  input  logic [RELAY_W-1:0] relay_hold,
  input  logic               ptt_one,
  input  logic               ptt_two,
  output decision_t          decision
);

  localparam logic [2:0] PICK_NONE    = 3'd0;
  localparam logic [2:0] PICK_R1      = 3'd1;
  localparam logic [2:0] PICK_R1_MUTE = 3'd2;
  localparam logic [2:0] PICK_R2      = 3'd3;
  localparam logic [2:0] PICK_R2_MUTE = 3'd4;

  logic [RELAY_W-1:0] r;
  seq_cmd_t           c1;
  seq_cmd_t           c2;
  logic               exit_both;
  logic [2:0]         pick;
  logic               cmd;
  logic               f1_on;
  logic               f2_on;
  logic               a1_on;
  logic               a2_on;
  logic               a1_off;
  logic               a2_off;
  logic               m_on;
  logic               m_off;

  always_comb begin
    r         = relay_hold;
    c1        = CMD_NONE;
    c2        = CMD_NONE;
    exit_both = 1'b0;
    pick      = PICK_NONE;
    cmd       = 1'b1;
    f1_on     = (settings.fsw_one == SET_ON);
    f2_on     = (settings.fsw_two == SET_ON);
    a1_on     = (settings.ant_one == SET_ON);
    a2_on     = (settings.ant_two == SET_ON);
    a1_off    = (settings.ant_one == SET_OFF);
    a2_off    = (settings.ant_two == SET_OFF);
    m_on      = (settings.mute == SET_ON);
    m_off     = (settings.mute == SET_OFF);

    if (settings.support_op == SET_OFF) begin
      r = r & ~(K4 | K8 | K10 | TRANS);
      if (f1_on || f2_on) begin
        if (f1_on && !ptt_one) c1 = CMD_ENTER;
        if (f2_on && !ptt_two) c2 = CMD_ENTER;
      end else if (a1_off && a2_off) begin
        r = r & ~(K5K6 | K9 | K11 | K13);
        exit_both = 1'b1;
      end else if (a1_on && a2_off) begin
        r = r | K5K6 | K9;
        r = r & ~(K11 | K13 | K14);
        exit_both = 1'b1;
      end else if (a1_off && a2_on) begin
        r = r & ~(K5K6 | K9 | K12);
        r = r | K11 | K13;
        exit_both = 1'b1;
      end else if (a1_on && a2_on) begin
        r = r | K5K6 | K9 | K11 | K13;
        r = r & ~(K14 | K12);
        exit_both = 1'b1;
      end
    end else if (settings.fsw_one == SET_OFF && settings.fsw_two == SET_OFF) begin
      r = r & ~TRANS;
      if (a1_off && a2_off) begin
        r = r | K4 | K8 | K10 | K13;
        r = r & ~(K5K6 | K12);
        exit_both = 1'b1;
      end else if (a1_on && a2_off) begin
        r = r | K4 | K5K6 | K9 | K10 | K13;
        r = r & ~(K8 | K14);
        exit_both = 1'b1;
      end else if (a1_off && a2_on) begin
        r = r | K4 | K11 | K12 | K13;
        r = r & ~(K5K6 | K10 | K14);
        exit_both = 1'b1;
      end else if (a1_on && a2_on) begin
        r = r | K4 | K5K6 | K9 | K11 | K12 | K13;
        r = r & ~(K8 | K10 | K14);
        exit_both = 1'b1;
      end
    end else begin
      if (settings.prio_sel == PRIO_ONE || settings.prio_sel == PRIO_FIRST) begin
        if (f1_on && m_off)      pick = PICK_R1;
        else if (f1_on && m_on)  pick = PICK_R1_MUTE;
        else if (f2_on && m_off) pick = PICK_R2;
        else if (f2_on && m_on)  pick = PICK_R2_MUTE;
        cmd = (settings.prio_sel == PRIO_ONE);
      end else if (settings.prio_sel == PRIO_TWO) begin
        if (f2_on && m_off)      pick = PICK_R2;
        else if (f2_on && m_on)  pick = PICK_R2_MUTE;
        else if (f1_on && m_off) pick = PICK_R1;
        else if (f1_on && m_on)  pick = PICK_R1_MUTE;
      end
      if (cmd) begin
        case (pick)
          PICK_R1: begin
            r = r | K4 | K11 | K12 | K13;
            r = r & ~(K10 | K14 | TRANS);
            c1 = CMD_ENTER;
          end
          PICK_R1_MUTE: begin
            r = r | K4 | K13;
            r = r & ~(K10 | K11 | K14 | TRANS);
            c1 = CMD_ENTER;
          end
          PICK_R2: begin
            r = r | K4 | K5K6 | K9 | K13 | K14 | TRANS;
            r = r & ~(K8 | K12);
            c2 = CMD_ENTER;
          end
          PICK_R2_MUTE: begin
            r = r | K4 | K5K6 | K13 | TRANS;
            r = r & ~(K8 | K9 | K12);
            c2 = CMD_ENTER;
          end
          default: begin
          end
        endcase
      end else begin
        case (pick)
          PICK_R1: begin
            r = r | K4 | K11 | K13;
            r = r & ~(K10 | TRANS);
          end
          PICK_R1_MUTE: begin
            r = r | K4 | K13;
            r = r & ~(K10 | K11 | TRANS);
          end
          PICK_R2: begin
            r = r | K4 | K5K6 | K9 | K13 | TRANS;
            r = r & ~K8;
          end
          PICK_R2_MUTE: begin
            r = r | K4 | K5K6 | K13 | TRANS;
            r = r & ~(K8 | K9);
          end
          default: begin
          end
        endcase
      end
    end

    if (exit_both) begin
      if (ptt_one) c1 = CMD_EXIT;
      if (ptt_two) c2 = CMD_EXIT;
    end

    decision.relay   = r & RELAY_MASK;
    decision.cmd_one = c1;
    decision.cmd_two = c2;
  end

endmodule

### sv/dual_radio_relay_state_control.sv
// Dual-radio relay and transmit-sequencer control, top level.
// An accepted request passes from the request register to the result register; res_stall can hold it between them.
// Throughput: one request per cycle while the result is not stalled; the decision table is a single pass of flat logic.
// Reset (rst, synchronous): settings, held relays and both valids cleared.
// Depends on drrsc_pkg and drrsc_decide.
module dual_radio_relay_state_control import drrsc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               evt_valid,
  output logic               evt_stall,
  input  logic [2:0]         mode,
  input  logic [1:0]         value,
  input  logic               ptt_active_one,
  input  logic               ptt_active_two,
  output logic               res_valid,
  input  logic               res_stall,
  output logic [RELAY_W-1:0] relay_lines,
  output logic [1:0]         seq_cmd_one,
  output logic [1:0]         seq_cmd_two
);

  logic               req_valid;
  logic [2:0]         req_mode;
  logic [1:0]         req_value;
  logic               req_ptt_one;
  logic               req_ptt_two;
  settings_t          settings;
  settings_t          settings_next;
  logic [RELAY_W-1:0] relay_hold;
  decision_t          decision;
  logic               res_free;
  logic               advance;

  assign res_free  = !res_valid || !res_stall;
  assign advance   = req_valid && res_free;
  assign evt_stall = req_valid && !res_free;

  always_comb begin
    settings_next = settings;
    case (req_mode)
      MODE_FSW_ONE: settings_next.fsw_one    = req_value;
      MODE_FSW_TWO: settings_next.fsw_two    = req_value;
      MODE_SUPPORT: settings_next.support_op = req_value;
      MODE_PRIO:    settings_next.prio_sel   = req_value;
      MODE_ANT_ONE: settings_next.ant_one    = req_value;
      MODE_ANT_TWO: settings_next.ant_two    = req_value;
      MODE_MUTE:    settings_next.mute       = req_value;
      default:      settings_next            = settings;
    endcase
  end

  drrsc_decide u_decide (
    .settings   (settings_next),
    .relay_hold (relay_hold),
    .ptt_one    (req_ptt_one),
    .ptt_two    (req_ptt_two),
    .decision   (decision)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!evt_stall) begin
      req_valid <= evt_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (evt_valid && !evt_stall) begin
      req_mode    <= mode;
      req_value   <= value;
      req_ptt_one <= ptt_active_one;
      req_ptt_two <= ptt_active_two;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      settings   <= '0;
      relay_hold <= '0;
    end else if (advance) begin
      settings   <= settings_next;
      relay_hold <= decision.relay;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_free) begin
      res_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      relay_lines <= decision.relay;
      seq_cmd_one <= decision.cmd_one;
      seq_cmd_two <= decision.cmd_two;
    end
  end

endmodule

### sv/drrsc_checker.sv
// Port-level checker for the dual-radio relay control block, bound to the top level.
// Depends on drrsc_pkg and dual_radio_relay_state_control_assert.svh.
`include "dual_radio_relay_state_control_assert.svh"

module drrsc_checker import drrsc_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               evt_stall,
  input logic               res_valid,
  input logic               res_stall,
  input logic [RELAY_W-1:0] relay_lines,
  input logic [1:0]         seq_cmd_one,
  input logic [1:0]         seq_cmd_two
);

  logic [RELAY_W+3:0] res_word;
  logic               cmd_legal;
  logic               any_exit;
  logic               any_enter;

  assign res_word  = {relay_lines, seq_cmd_one, seq_cmd_two};
  assign cmd_legal = seq_cmd_one != CMD_INVALID && seq_cmd_two != CMD_INVALID;
  assign any_exit  = seq_cmd_one == CMD_EXIT || seq_cmd_two == CMD_EXIT;
  assign any_enter = seq_cmd_one == CMD_ENTER || seq_cmd_two == CMD_ENTER;

  `DRRSC_ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid && $stable(res_word))
  `DRRSC_ASSERT_NOW(a_spare_clear, res_valid, !relay_lines[RELAY_W-1] && cmd_legal)
  `DRRSC_ASSERT_NOW(a_exit_no_enter, res_valid && any_exit, !any_enter)
  `DRRSC_ASSERT_NOW(a_reset_empty, $past(rst), !res_valid && !evt_stall)

endmodule

bind dual_radio_relay_state_control drrsc_checker u_drrsc_checker (.*);
